// ===== hdl/pfc_pkg.sv =====
// Package for the Playfair digraph cipher unit: letter codes, opcodes,
// controller/datapath command and status structs, and square geometry helpers.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  // Square geometry
  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;
  typedef logic [1:0] op_t;

  // Operation codes carried on the input tuser
  localparam op_t OP_KEY    = 2'd0;
  localparam op_t OP_FINISH = 2'd1;
  localparam op_t OP_MSG    = 2'd2;
  localparam op_t OP_END    = 2'd3;

  // Letter indexes (A = 0)
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Q = 5'd16;
  localparam letter_t LETTER_Z = 5'd25;
  localparam letter_t LETTER_X = 5'd23;

  // ASCII bounds
  localparam logic [7:0] ASCII_UP_A = 8'h41;
  localparam logic [7:0] ASCII_UP_Z = 8'h5A;
  localparam logic [7:0] ASCII_LO_A = 8'h61;
  localparam logic [7:0] ASCII_LO_Z = 8'h7A;
  localparam logic [6:0] ASCII_A7   = 7'h41;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic place_key;
    logic fill_start;
    logic fill_step;
    logic set_ready;
    logic hold;
    logic pair_msg;
    logic pair_end;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic letter_ok;
    logic square_ready;
    logic held_valid;
    logic k_last;
    logic out_busy;
  } dp_status_t;

  // Map an ASCII byte to a letter index with J folded into I; ok low for non-letters
  function automatic logic [5:0] fold_char(input logic [7:0] ch);
    logic [7:0] diff;
    logic       ok;
    letter_t    idx;
    diff = 8'd0;
    ok   = 1'b0;
    if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
      diff = ch - ASCII_UP_A;
      ok   = 1'b1;
    end else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
      diff = ch - ASCII_LO_A;
      ok   = 1'b1;
    end
    idx = diff[4:0];
    if (idx == LETTER_J) begin
      idx = LETTER_I;
    end
    return {ok, idx};
  endfunction

  // Pad letter for a doubled or odd trailing letter
  function automatic letter_t pad_for(input letter_t a);
    return (a == LETTER_X) ? LETTER_Q : LETTER_X;
  endfunction

  // Row of a cell index 0..24
  function automatic coord_t cell_row(input cell_t c);
    coord_t r;
    priority if (c >= 5'd20) r = 3'd4;
    else if (c >= 5'd15)     r = 3'd3;
    else if (c >= 5'd10)     r = 3'd2;
    else if (c >= 5'd5)      r = 3'd1;
    else                     r = 3'd0;
    return r;
  endfunction

  // Column of a cell index 0..24
  function automatic coord_t cell_col(input cell_t c);
    cell_t t;
    t = c - 5'(cell_row(c)) * 5'(SIDE);
    return t[2:0];
  endfunction

  // Cell index from row and column
  function automatic cell_t cell_at(input coord_t r, input coord_t c);
    return 5'(r) * 5'(SIDE) + 5'(c);
  endfunction

  // Step one position with wraparound
  function automatic coord_t wrap_inc(input coord_t v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pfc_ctrl.sv =====
// Controller state machine for the Playfair cipher unit.
// Sequences key placement, square completion and digraph lookup; uses pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_ADDR   = 3'd4;
  localparam logic [2:0] S_LOAD   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        unique case (status.op)
          OP_KEY: begin
            cmd.place_key = !status.square_ready && status.letter_ok;
          end
          OP_FINISH: begin
            if (!status.square_ready) begin
              cmd.fill_start = 1'b1;
              state_nxt      = S_FILL;
            end
          end
          OP_MSG: begin
            if (status.square_ready && status.letter_ok) begin
              if (!status.held_valid) begin
                cmd.hold = 1'b1;
              end else begin
                cmd.pair_msg = 1'b1;
                state_nxt    = S_LOOKUP;
              end
            end
          end
          OP_END: begin
            if (status.square_ready && status.held_valid) begin
              cmd.pair_end = 1'b1;
              state_nxt    = S_LOOKUP;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.k_last) begin
          cmd.set_ready = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LOOKUP: state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_LOAD;
      S_LOAD: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pfc_datapath.sv =====
// Datapath of the Playfair cipher unit: key square and letter position
// memories, used-letter map, pair registers and output stage; uses pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfc_datapath
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_tdata,
  input  wire logic [1:0] in_tuser,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status
);

  // Key square memories
  letter_t sq_mem   [CELLS];
  cell_t   cell_mem [LETTERS];

  op_t                op_r;
  letter_t            letter_r;
  logic               letter_ok_r;
  logic [LETTERS-1:0] used_r;
  cell_t              fill_r;
  logic               ready_r;
  letter_t            held_r;
  logic               held_valid_r;
  letter_t            k_r;
  letter_t            a_r;
  letter_t            b_r;
  cell_t              ca_r;
  cell_t              cb_r;
  letter_t            sq_x_r;
  letter_t            sq_y_r;
  letter_t            out_x_r;
  letter_t            out_y_r;
  logic               out_busy_r;
  logic               out_second_r;

  logic [5:0] folded;
  letter_t    place_src;
  logic       do_place;
  logic       same_letter;
  coord_t     r1, c1, r2, c2;
  cell_t      cx, cy;
  logic       out_pop;

  assign folded      = fold_char(in_tdata);
  assign same_letter = (letter_r == held_r);

  // Pick the letter to place and check that it fits
  assign place_src = cmd.place_key ? letter_r : k_r;
  assign do_place  = (cmd.place_key || (cmd.fill_step && k_r != LETTER_J))
                     && !used_r[place_src] && (fill_r < 5'(CELLS));

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r        <= in_tuser;
      letter_r    <= folded[4:0];
      letter_ok_r <= folded[5];
    end
  end

  // Write both square memories on a placement
  always_ff @(posedge clk) begin
    if (do_place) begin
      sq_mem[fill_r]      <= place_src;
      cell_mem[place_src] <= fill_r;
    end
  end

  // Look up letter positions, then the replacement letters
  always_ff @(posedge clk) begin
    ca_r   <= cell_mem[a_r];
    cb_r   <= cell_mem[b_r];
    sq_x_r <= sq_mem[cx];
    sq_y_r <= sq_mem[cy];
  end

  // Apply the same-row, same-column or rectangle rule
  always_comb begin
    r1 = cell_row(ca_r);
    c1 = cell_col(ca_r);
    r2 = cell_row(cb_r);
    c2 = cell_col(cb_r);
    priority if (r1 == r2) begin
      cx = cell_at(r1, wrap_inc(c1));
      cy = cell_at(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      cx = cell_at(wrap_inc(r1), c1);
      cy = cell_at(wrap_inc(r2), c2);
    end else begin
      cx = cell_at(r1, c2);
      cy = cell_at(r2, c1);
    end
  end

  // Square build control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      fill_r  <= '0;
      ready_r <= 1'b0;
      k_r     <= '0;
    end else begin
      if (do_place) begin
        used_r[place_src] <= 1'b1;
        fill_r            <= fill_r + 5'd1;
      end
      if (cmd.fill_start) begin
        k_r <= '0;
      end else if (cmd.fill_step) begin
        k_r <= k_r + 5'd1;
      end
      if (cmd.set_ready) begin
        ready_r <= 1'b1;
      end
    end
  end

  // Held letter and pair formation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else begin
      if (cmd.hold) begin
        held_r       <= letter_r;
        held_valid_r <= 1'b1;
      end else if (cmd.pair_msg) begin
        if (!same_letter) begin
          held_r       <= '0;
          held_valid_r <= 1'b0;
        end
      end else if (cmd.pair_end) begin
        held_r       <= '0;
        held_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_msg) begin
      a_r <= held_r;
      b_r <= same_letter ? pad_for(held_r) : letter_r;
    end else if (cmd.pair_end) begin
      a_r <= held_r;
      b_r <= pad_for(held_r);
    end
  end

  // Output stage: two words per digraph
  assign out_pop = out_busy_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_busy_r   <= 1'b0;
      out_second_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_busy_r   <= 1'b1;
        out_second_r <= 1'b0;
      end else if (out_pop) begin
        if (out_second_r) begin
          out_busy_r   <= 1'b0;
          out_second_r <= 1'b0;
        end else begin
          out_second_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x_r <= sq_x_r;
      out_y_r <= sq_y_r;
    end
  end

  assign out_tvalid = out_busy_r;
  assign out_tlast  = out_second_r;
  assign out_tdata  = {1'b0, ASCII_A7 + 7'(out_second_r ? out_y_r : out_x_r)};

  // Status to the controller
  assign status.op           = op_r;
  assign status.letter_ok    = letter_ok_r;
  assign status.square_ready = ready_r;
  assign status.held_valid   = held_valid_r;
  assign status.k_last       = (k_r == LETTER_Z);
  assign status.out_busy     = out_busy_r;

endmodule

`default_nettype wire

// ===== hdl/playfair_digraph_cipher_unit.sv =====
// Top level of the Playfair digraph cipher unit: controller plus datapath.
// Depends on pfc_pkg, pfc_ctrl and pfc_datapath.
//
// Usage: build the key square, then stream the message.
//   Input channel in_*: tuser = op (0 key char, 1 finish square, 2 message
//   char, 3 end of message), tdata = ASCII character byte.
//   Result channel out_*: tdata[6:0] = cipher letter 'A'..'Z', tlast marks
//   the second letter of each encrypted digraph.
// One word is taken at a time; in_tready is high while the controller idles.
//   Key character: accepted, then placed.
//   Finish: accept, decode, then a walk over the 26 letters, one letter per cycle.
//   Message letter that closes a pair: accept, decode, then the two registered
//   memory reads (letter positions, then replacement letters), then the output load.
//   Other message words: accepted, then decoded.
// A digraph sits in the output stage while the next words are taken; a
// following pair waits in its last step until the stage has drained, so
// out_tready low stalls the input only once a second pair is ready.
// Reset clears the used-letter map, fill count, square-ready flag, held
// letter and output stage; the square memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher_unit
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic [1:0] in_tuser,   // [1:0] op
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] cipher_char, [7] zero
  output logic            out_tlast   // pair_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pfc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== hdl/pfc_checker.sv =====
// Port-level checker for the Playfair cipher unit, bound to the top level.
// Watches only the top level's ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pfc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // The second letter of a digraph follows the first at once
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("digraph second letter missing");

  // Every cipher word is an uppercase letter
  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'h41) && (out_tdata <= 8'h5A))
    else $error("cipher word out of letter range");

endmodule

bind playfair_digraph_cipher_unit pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
